### sv/sem_pkg.sv
// Package with shared types, constants and arithmetic helpers of the Sobel edge block.
`timescale 1ns / 1ps
package sem_pkg;
  localparam int MaxWidth   = 2048;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int CfgW       = 12;
  localparam int PixW       = 24;
  localparam int NumCells   = 8;   // one magnitude bit per cell
  localparam int RadW       = 17;  // gx*gx + gy*gy fits 17 bits

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [7:0] chan_t;

  // Data handed from one square-root cell to the next, for all three channels.
  typedef struct packed {
    logic [2:0][RadW-1:0] rem;
    logic [2:0][7:0]      root;
    logic                 eof;
  } sqrt_bus_t;

  // Sobel sum of one orientation, clamped to 0..255.
  function automatic logic [7:0] clamp_sum(input logic signed [11:0] s);
    logic [7:0] r;
    if (s < 0) r = 8'd0;
    else if (s > 12'sd255) r = 8'd255;
    else r = s[7:0];
    return r;
  endfunction
endpackage

### sv/sem_stream_if.sv
// Valid/ready stream interface carrying one item of a given payload type.
`timescale 1ns / 1ps
interface sem_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/sobel_edge_magnitude.sv
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Throughput: one pixel item per clock while the output side takes items; the input
// waits after reset and after a size change that moves the column.
// An accepted pixel passes the kernel stage, the squaring stage and eight
// square-root cells of one root bit each before its result appears.
// Reset clears counters, the window and the valid bits of the chain; line store
// contents stay undefined until written.
`timescale 1ns / 1ps
module sobel_edge_magnitude (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [sem_pkg::CfgW-1:0]   cfg_data,
  sem_stream_if.sink                 in_pix,
  sem_stream_if.source               out_edge
);
  import sem_pkg::*;

  // The whole pipeline advances when the result register can move.
  logic              en;
  logic              vld_k_r, vld_sq_r;
  wire  [NumCells:0] vld_chain;
  assign en = !vld_chain[NumCells] || out_edge.ready;

  // Configuration registers; only the low 12 bits exist.
  logic [CfgW-1:0] width_r, height_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CfgW'(640);
      height_r <= CfgW'(480);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame size after clamping.
  logic [ColW:0]   w_eff;
  logic [CfgW-1:0] h_eff;
  always_comb begin
    if (width_r < CfgW'(3)) w_eff = (ColW+1)'(3);
    else if (width_r > CfgW'(MaxWidth)) w_eff = (ColW+1)'(MaxWidth);
    else w_eff = (ColW+1)'(width_r);
    h_eff = (height_r < CfgW'(3)) ? CfgW'(3) : height_r;
  end

  // Raster position of the next pixel.
  logic [ColW-1:0] col_r, col_nxt, c;
  logic [CfgW-1:0] row_r, row_nxt;
  logic            last_col, last_row;
  always_comb begin
    c = ({1'b0, col_r} >= w_eff) ? ColW'(w_eff - 1'b1) : col_r;
    last_col = ({1'b0, c} >= w_eff - 1'b1);
    last_row = (row_r >= h_eff - 1'b1);
    col_nxt = last_col ? '0 : c + 1'b1;
    row_nxt = last_col ? (last_row ? '0 : row_r + 1'b1) : row_r;
  end

  // Line stores: the entries of the next column are read ahead into registers
  // while the current column is rewritten. A pixel is taken only when the
  // registered read belongs to its column; after reset, or after a size change
  // that moves the column, the input waits while the right column is read.
  logic [PixW-1:0] older_mem [MaxWidth];
  logic [PixW-1:0] newer_mem [MaxWidth];
  logic [PixW-1:0] px, top, mid, top_r, mid_r;
  logic [ColW-1:0] rd_addr, rd_addr_r;
  logic            rd_ok_r, hit, acc;
  assign hit = rd_ok_r && (rd_addr_r == c);
  assign in_pix.ready = en && hit;
  assign acc = in_pix.valid && en && hit;
  assign rd_addr = acc ? col_nxt : c;
  assign px  = {in_pix.data.pixel_red, in_pix.data.pixel_green,
                in_pix.data.pixel_blue};
  assign top = top_r;
  assign mid = mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r   <= 1'b0;
      rd_addr_r <= '0;
    end else begin
      rd_ok_r   <= 1'b1;
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= older_mem[rd_addr];
    mid_r <= newer_mem[rd_addr];
    if (acc) begin
      older_mem[c] <= mid_r;
      newer_mem[c] <= px;
    end
  end

  // Window columns c-2 (index 0..2) and c-1 (3..5), top to bottom.
  logic [5:0][PixW-1:0] win_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      win_r <= {px, mid, top, win_r[5], win_r[4], win_r[3]};
    end
  end

  // Kernel stage: clamped gx, gy per channel.
  logic [2:0][7:0] gx_nxt, gy_nxt, gx_r, gy_r;
  logic            emit, eof_nxt, eof_s1_r;
  always_comb begin
    logic signed [11:0] sx, sy;
    logic signed [11:0] p [3][3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int l = 0; l < 3; l++) begin
        p[0][l] = 12'(win_r[l][8*ch +: 8]);
        p[1][l] = 12'(win_r[3+l][8*ch +: 8]);
      end
      p[2][0] = 12'(top[8*ch +: 8]);
      p[2][1] = 12'(mid[8*ch +: 8]);
      p[2][2] = 12'(px[8*ch +: 8]);
      sx = 12'((p[2][0] + 2*p[2][1] + p[2][2]) - (p[0][0] + 2*p[0][1] + p[0][2]));
      sy = 12'((p[0][2] + 2*p[1][2] + p[2][2]) - (p[0][0] + 2*p[1][0] + p[2][0]));
      gx_nxt[ch] = clamp_sum(sx);
      gy_nxt[ch] = clamp_sum(sy);
    end
    emit    = (c >= ColW'(2)) && (row_r >= CfgW'(2));
    eof_nxt = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_k_r <= 1'b0;
    end else if (en) begin
      vld_k_r <= acc && emit;
    end
    if (en) begin
      gx_r     <= gx_nxt;
      gy_r     <= gy_nxt;
      eof_s1_r <= eof_nxt;
    end
  end

  // Squaring stage feeds the root chain.
  logic [2:0][RadW-1:0] sq_sum;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sq_sum[ch] = RadW'(gx_r[ch]) * RadW'(gx_r[ch]) + RadW'(gy_r[ch]) * RadW'(gy_r[ch]);
    end
  end

  sqrt_bus_t sq_bus_r;
  sqrt_bus_t chain [NumCells+1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_sq_r <= 1'b0;
    end else if (en) begin
      vld_sq_r <= vld_k_r;
    end
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        sq_bus_r.rem[ch]  <= sq_sum[ch];
        sq_bus_r.root[ch] <= '0;
      end
      sq_bus_r.eof <= eof_s1_r;
    end
  end
  assign chain[0]     = sq_bus_r;
  assign vld_chain[0] = vld_sq_r;

  // Chain of cells, most significant root bit first. The root of a value
  // below 2^17 is at most 362, so it saturates to 255 when it reaches 256.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    sem_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .bit_sel   (3'(NumCells - 1 - i)),
      .valid_in  (vld_chain[i]),
      .bus_in    (chain[i]),
      .valid_out (vld_chain[i+1]),
      .bus_out   (chain[i+1])
    );
  end

  // Any value of 65536 or more has root above 255: saturate.
  logic [NumCells:0][2:0] big;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        big[0][ch] <= sq_sum[ch] >= RadW'(65536);
      end
      for (int i = 1; i <= NumCells; i++) big[i] <= big[i-1];
    end
  end

  // big[NumCells] lines up with chain[NumCells] after its final cell.
  assign out_edge.valid = vld_chain[NumCells];
  assign out_edge.data.edge_red   = big[NumCells][2] ? 8'hFF : chain[NumCells].root[2];
  assign out_edge.data.edge_green = big[NumCells][1] ? 8'hFF : chain[NumCells].root[1];
  assign out_edge.data.edge_blue  = big[NumCells][0] ? 8'hFF : chain[NumCells].root[0];
  assign out_edge.data.end_of_frame = chain[NumCells].eof;
endmodule

### sv/sem_sqrt_cell.sv
// One restoring square-root cell: decides one bit of the root for three channels.
`timescale 1ns / 1ps
module sem_sqrt_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [2:0]             bit_sel,
  input  logic                   valid_in,
  input  sem_pkg::sqrt_bus_t     bus_in,
  output logic                   valid_out,
  output sem_pkg::sqrt_bus_t     bus_out
);
  import sem_pkg::*;
  sqrt_bus_t bus_nxt;
  logic      valid_r;
  sqrt_bus_t bus_r;

  always_comb begin
    logic [RadW-1:0] trial;
    bus_nxt = bus_in;
    for (int ch = 0; ch < 3; ch++) begin
      trial = RadW'((({9'd0, bus_in.root[ch]} | (17'd1 << bit_sel)) *
                     ({9'd0, bus_in.root[ch]} | (17'd1 << bit_sel))));
      if (trial <= bus_in.rem[ch]) begin
        bus_nxt.root[ch] = bus_in.root[ch] | (8'd1 << bit_sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
    if (en) begin
      bus_r <= bus_nxt;
    end
  end

  assign valid_out = valid_r;
  assign bus_out   = bus_r;
endmodule
